// ----- rtl/core/ttop_pkg.sv -----
// Package with types, constants and codes of the timer table.
package ttop_pkg;

   localparam int TIMER_SLOTS_DEF = 16;
   localparam int MAX_FIRES_DEF   = 63;

   typedef enum logic [1:0] {
      CMD_CREATE_ONE  = 2'd0,
      CMD_CREATE_PER  = 2'd1,
      CMD_CANCEL      = 2'd2,
      CMD_ADVANCE     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_CREATED    = 3'd0,
      KIND_FULL       = 3'd1,
      KIND_CANCELLED  = 3'd2,
      KIND_NOT_FOUND  = 3'd3,
      KIND_FIRED      = 3'd4,
      KIND_ADV_DONE   = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CREATE,
      ST_WALK_REQ,
      ST_WALK_CHK,
      ST_UPDATE,
      ST_RESCHED,
      ST_PASS_END,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/ttop_ram.sv -----
// Generic RAM with one write port and one read port, with registered read.
module ttop_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/core/timer_table_one_shot_periodic_top.sv -----
// Top level of the timer table: command sequencer around the slot memory.
//
// A command item is accepted when start is high and busy is low. Its fields
// are the req_ ports: command, interval, owner, cancel id and time delta.
// Results appear on the rsp_ ports for one cycle each, marked by rsp_valid,
// and the receiver cannot stall them. Each item gives one result, except
// an advance, which gives one result per fired timer and then an advance
// done result; rsp_last marks the final result of an item.
// The slot record (id, owner, periodic flag, period, expiry, link) lives in
// one synchronous RAM with a registered read; valid bits, the list head, the
// id counter and the simulated time are flip-flops. A create picks the lowest
// free slot at once and shows its result in the cycle after acceptance. Each
// timer walked takes a request and a check state; a non-head timer that is
// unlinked also has its predecessor read back and rewritten. An advance walks
// the list in passes: a fired timer adds an update state, each pass ends in a
// pass-end state, and passes repeat while timers fire, up to the fire cap; a
// done state shows the done result. Busy stays high until the final result
// is shown. Reset clears the valid bits, empties the list, sets the id counter
// to one and the time to zero; the block is ready as soon as reset is
// released.
module timer_table_one_shot_periodic_top
   import ttop_pkg::*;
#(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
   parameter int MAX_FIRES_PER_ADVANCE = MAX_FIRES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_interval_us,
   input  logic [31:0] req_owner,
   input  logic [31:0] req_cancel_id,
   input  logic [63:0] req_delta_us,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_handle,
   output logic [31:0] rsp_fire_owner,
   output logic [63:0] rsp_now_us,
   output logic        rsp_more_pending,
   output logic        rsp_last
);
   localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int LW = $clog2(TIMER_SLOTS + 1);
   localparam int FW = $clog2(MAX_FIRES_PER_ADVANCE + 1);
   localparam int RW = 32 + 32 + 1 + 32 + 64 + LW;
   localparam logic [LW-1:0] LIST_END = LW'(TIMER_SLOTS);

   typedef struct packed {
      logic [31:0]   id;
      logic [31:0]   owner;
      logic          periodic;
      logic [31:0]   period;
      logic [63:0]   expiry;
      logic [LW-1:0] link;
   } rec_type;

   state_type state_ff, state_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [LW-1:0] head_ff, head_in;
   logic [31:0]   idc_ff, idc_in;
   logic [63:0]   now_ff, now_in;
   cmd_type       cmd_ff, cmd_in;
   logic [31:0]   arg_ff, arg_in;
   logic [31:0]   own_ff, own_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] prev_ff, prev_in;
   logic [FW-1:0] fires_ff, fires_in;
   logic          fired_ff, fired_in;
   logic          capped_ff, capped_in;
   rec_type       rec_ff, rec_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   rec_type       wdata, rdata;
   logic [RW-1:0] rdata_raw;

   logic          o_valid, o_last, o_more;
   kind_type      o_kind;
   logic [31:0]   o_id, o_owner;
   logic          free_found;
   logic [AW-1:0] free_idx;
   logic [63:0]   new_exp;

   ttop_ram #(.WIDTH(RW), .DEPTH(TIMER_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (RW'(wdata)),
      .rd_addr (raddr),
      .rd_data (rdata_raw)
   );
   assign rdata = rec_type'(rdata_raw);

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   assign new_exp = rec_ff.expiry + {32'd0, rec_ff.period};
   assign raddr = cur_in[AW-1:0];

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      head_in = head_ff;
      idc_in = idc_ff;
      now_in = now_ff;
      cmd_in = cmd_ff;
      arg_in = arg_ff;
      own_in = own_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      fires_in = fires_ff;
      fired_in = fired_ff;
      capped_in = capped_ff;
      rec_in = rec_ff;
      we = 1'b0;
      waddr = cur_ff[AW-1:0];
      wdata = rec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = cmd_type'(req_command);
               arg_in = (req_command == CMD_CANCEL) ? req_cancel_id : req_interval_us;
               own_in = req_owner;
               cur_in = head_ff;
               prev_in = LIST_END;
               fires_in = '0;
               fired_in = 1'b0;
               capped_in = 1'b0;
               priority case (req_command)
                  CMD_CREATE_ONE, CMD_CREATE_PER: state_in = ST_CREATE;
                  CMD_CANCEL: state_in = ST_WALK_REQ;
                  default: begin
                     now_in = now_ff + req_delta_us;
                     state_in = ST_WALK_REQ;
                  end
               endcase
            end
         end
         ST_CREATE: begin
            if (free_found) begin
               we = 1'b1;
               waddr = free_idx;
               wdata.id = idc_ff;
               wdata.owner = own_ff;
               wdata.periodic = (cmd_ff == CMD_CREATE_PER);
               wdata.period = (cmd_ff == CMD_CREATE_PER && arg_ff == 32'd0) ? 32'd1 : arg_ff;
               wdata.expiry = now_ff + {32'd0, arg_ff};
               wdata.link = head_ff;
               valid_in[free_idx] = 1'b1;
               head_in = LW'(free_idx);
               idc_in = idc_ff + 32'd1;
            end
            state_in = ST_IDLE;
         end
         ST_WALK_REQ: begin
            if (cur_ff == LIST_END) begin
               state_in = (cmd_ff == CMD_CANCEL) ? ST_IDLE : ST_PASS_END;
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            rec_in = rdata;
            state_in = ST_UPDATE;
            if (cmd_ff == CMD_CANCEL) begin
               if (rdata.id == arg_ff) begin
                  if (prev_ff == LIST_END) begin
                     head_in = rdata.link;
                  end else begin
                     state_in = ST_RESCHED;
                  end
                  valid_in[cur_ff[AW-1:0]] = 1'b0;
                  if (prev_ff == LIST_END) state_in = ST_IDLE;
               end else begin
                  prev_in = cur_ff;
                  cur_in = rdata.link;
                  state_in = ST_WALK_REQ;
               end
            end else if (rdata.expiry <= now_ff) begin
               if (fires_ff == FW'(MAX_FIRES_PER_ADVANCE)) begin
                  capped_in = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               prev_in = cur_ff;
               cur_in = rdata.link;
               state_in = ST_WALK_REQ;
            end
         end
         ST_UPDATE: begin
            fires_in = fires_ff + FW'(1);
            fired_in = 1'b1;
            if (rec_ff.periodic) begin
               we = 1'b1;
               wdata.expiry = new_exp;
               prev_in = cur_ff;
               cur_in = rec_ff.link;
               state_in = ST_WALK_REQ;
            end else begin
               valid_in[cur_ff[AW-1:0]] = 1'b0;
               cur_in = rec_ff.link;
               if (prev_ff == LIST_END) begin
                  head_in = rec_ff.link;
                  state_in = ST_WALK_REQ;
               end else begin
                  cur_in = prev_ff;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Read back the predecessor record to relink it.
            state_in = ST_RESCHED;
         end
         ST_RESCHED: begin
            we = 1'b1;
            waddr = prev_ff[AW-1:0];
            if (cmd_ff == CMD_CANCEL) begin
               wdata = rdata;
               wdata.link = rec_ff.link;
               state_in = ST_IDLE;
            end else begin
               wdata = rdata;
               wdata.link = rec_ff.link;
               cur_in = rec_ff.link;
               state_in = ST_WALK_REQ;
            end
         end
         ST_PASS_END: begin
            if (fired_ff) begin
               fired_in = 1'b0;
               cur_in = head_ff;
               prev_in = LIST_END;
               state_in = ST_WALK_REQ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // A cancel that unlinks a middle entry needs the predecessor read first.
      if (state_ff == ST_WALK_CHK && cmd_ff == CMD_CANCEL && state_in == ST_RESCHED) begin
         state_in = ST_SCAN;
         cur_in = prev_ff;
      end
   end

   always_comb begin
      o_valid = 1'b0;
      o_kind = KIND_CREATED;
      o_id = '0;
      o_owner = '0;
      o_more = 1'b0;
      o_last = 1'b0;
      unique case (state_ff)
         ST_CREATE: begin
            o_valid = 1'b1;
            o_last = 1'b1;
            o_kind = free_found ? KIND_CREATED : KIND_FULL;
            o_id = free_found ? idc_ff : 32'd0;
         end
         ST_WALK_REQ: begin
            if (cmd_ff == CMD_CANCEL && cur_ff == LIST_END) begin
               o_valid = 1'b1;
               o_last = 1'b1;
               o_kind = KIND_NOT_FOUND;
               o_id = arg_ff;
            end
         end
         ST_WALK_CHK: begin
            if (cmd_ff == CMD_CANCEL && rdata.id == arg_ff && prev_ff == LIST_END) begin
               o_valid = 1'b1;
               o_last = 1'b1;
               o_kind = KIND_CANCELLED;
               o_id = arg_ff;
            end
         end
         ST_RESCHED: begin
            if (cmd_ff == CMD_CANCEL) begin
               o_valid = 1'b1;
               o_last = 1'b1;
               o_kind = KIND_CANCELLED;
               o_id = arg_ff;
            end
         end
         ST_UPDATE: begin
            o_valid = 1'b1;
            o_kind = KIND_FIRED;
            o_id = rec_ff.id;
            o_owner = rec_ff.owner;
         end
         ST_DONE: begin
            o_valid = 1'b1;
            o_last = 1'b1;
            o_kind = KIND_ADV_DONE;
            o_more = capped_ff;
         end
         default: o_valid = 1'b0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = o_valid;
   assign rsp_kind = o_kind;
   assign rsp_handle = o_id;
   assign rsp_fire_owner = o_owner;
   assign rsp_now_us = now_ff;
   assign rsp_more_pending = o_more;
   assign rsp_last = o_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         head_ff <= LIST_END;
         idc_ff <= 32'd1;
         now_ff <= '0;
         fires_ff <= '0;
         fired_ff <= 1'b0;
         capped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         head_ff <= head_in;
         idc_ff <= idc_in;
         now_ff <= now_in;
         fires_ff <= fires_in;
         fired_ff <= fired_in;
         capped_ff <= capped_in;
      end
      cmd_ff <= cmd_in;
      arg_ff <= arg_in;
      own_ff <= own_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      rec_ff <= rec_in;
   end

   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      fires_ff <= FW'(MAX_FIRES_PER_ADVANCE))
      else $error("fire count above cap");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("busy after final result");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LIST_END)
      else $error("list head out of range");
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the timer table: directed and random commands against a predictor.
module testbench;
   import ttop_pkg::*;

   localparam int SLOTS      = TIMER_SLOTS_DEF;
   localparam int FIRE_CAP   = MAX_FIRES_DEF;
   localparam int LIST_NONE  = SLOTS;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      kind_type    kind;
      logic [31:0] handle;
      logic [31:0] fire_owner;
      logic [63:0] now_us;
      logic        more_pending;
      logic        last;
   } timer_event_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [31:0] req_interval_us;
   logic [31:0] req_owner;
   logic [31:0] req_cancel_id;
   logic [63:0] req_delta_us;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_handle;
   logic [31:0] rsp_fire_owner;
   logic [63:0] rsp_now_us;
   logic        rsp_more_pending;
   logic        rsp_last;

   bit          tm_valid[SLOTS];
   logic [31:0] tm_id[SLOTS];
   logic [31:0] tm_owner[SLOTS];
   bit          tm_periodic[SLOTS];
   logic [63:0] tm_expiry[SLOTS];
   logic [31:0] tm_period[SLOTS];
   int          tm_link[SLOTS];
   int          tm_head;
   logic [31:0] next_id;
   logic [63:0] model_now;

   timer_event_t pending_events[$];
   int  error_count;
   int  items_sent;
   int  events_seen;
   int  fires_seen;
   int  capped_advances;
   int  idle_cycles;
   bit  steady_flow;

   timer_table_one_shot_periodic_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_interval_us(req_interval_us),
      .req_owner(req_owner), .req_cancel_id(req_cancel_id),
      .req_delta_us(req_delta_us), .rsp_valid(rsp_valid), .rsp_kind(rsp_kind),
      .rsp_handle(rsp_handle), .rsp_fire_owner(rsp_fire_owner),
      .rsp_now_us(rsp_now_us), .rsp_more_pending(rsp_more_pending),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic timer_event_t make_event(kind_type k, logic [31:0] id,
                                               logic [31:0] own, bit more, bit fin);
      timer_event_t e;
      e.kind = k;
      e.handle = id;
      e.fire_owner = own;
      e.now_us = model_now;
      e.more_pending = more;
      e.last = fin;
      return e;
   endfunction

   task automatic drop_slot(int prev, int cur);
      if (prev < SLOTS) begin
         tm_link[prev] = tm_link[cur];
      end else begin
         tm_head = tm_link[cur];
      end
      tm_valid[cur] = 1'b0;
   endtask

   task automatic predict_command(cmd_type cmd, logic [31:0] interval, logic [31:0] own,
                                  logic [31:0] cid, logic [63:0] delta);
      int free_slot;
      int cur;
      int prev;
      int nxt;
      int fires;
      bit capped;
      bit fired;
      free_slot = LIST_NONE;
      if (cmd == CMD_CREATE_ONE || cmd == CMD_CREATE_PER) begin
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!tm_valid[i]) free_slot = i;
         end
         if (free_slot == LIST_NONE) begin
            pending_events.push_back(make_event(KIND_FULL, 32'd0, 32'd0, 1'b0, 1'b1));
         end else begin
            tm_valid[free_slot] = 1'b1;
            tm_id[free_slot] = next_id;
            next_id = next_id + 32'd1;
            tm_owner[free_slot] = own;
            tm_periodic[free_slot] = (cmd == CMD_CREATE_PER);
            tm_period[free_slot] = (cmd == CMD_CREATE_PER && interval == 0) ? 32'd1 : interval;
            tm_expiry[free_slot] = model_now + {32'd0, interval};
            tm_link[free_slot] = tm_head;
            tm_head = free_slot;
            pending_events.push_back(make_event(KIND_CREATED, tm_id[free_slot], 32'd0,
                                                1'b0, 1'b1));
         end
      end else if (cmd == CMD_CANCEL) begin
         cur = tm_head;
         prev = LIST_NONE;
         while (cur < SLOTS && tm_id[cur] != cid) begin
            prev = cur;
            cur = tm_link[cur];
         end
         if (cur < SLOTS) begin
            drop_slot(prev, cur);
            pending_events.push_back(make_event(KIND_CANCELLED, cid, 32'd0, 1'b0, 1'b1));
         end else begin
            pending_events.push_back(make_event(KIND_NOT_FOUND, cid, 32'd0, 1'b0, 1'b1));
         end
      end else begin
         model_now = model_now + delta;
         fires = 0;
         capped = 1'b0;
         do begin
            cur = tm_head;
            prev = LIST_NONE;
            fired = 1'b0;
            while (cur < SLOTS && !capped) begin
               nxt = tm_link[cur];
               if (tm_expiry[cur] <= model_now) begin
                  if (fires >= FIRE_CAP) begin
                     capped = 1'b1;
                  end else begin
                     pending_events.push_back(make_event(KIND_FIRED, tm_id[cur],
                                                         tm_owner[cur], 1'b0, 1'b0));
                     fires++;
                     fired = 1'b1;
                     if (tm_periodic[cur]) begin
                        tm_expiry[cur] = tm_expiry[cur] + {32'd0, tm_period[cur]};
                        prev = cur;
                     end else begin
                        drop_slot(prev, cur);
                     end
                  end
               end else begin
                  prev = cur;
               end
               cur = nxt;
            end
         end while (fired && !capped);
         if (capped) capped_advances++;
         pending_events.push_back(make_event(KIND_ADV_DONE, 32'd0, 32'd0, capped, 1'b1));
      end
   endtask

   function automatic int gap_cycles();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic issue_command(cmd_type cmd, logic [31:0] interval, logic [31:0] own,
                                logic [31:0] cid, logic [63:0] delta);
      int gap;
      req_command <= cmd;
      req_interval_us <= interval;
      req_owner <= own;
      req_cancel_id <= cid;
      req_delta_us <= delta;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_command(cmd, interval, own, cid, delta);
      items_sent++;
      gap = gap_cycles();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic add_timer(bit periodic, logic [31:0] interval, logic [31:0] own);
      issue_command(periodic ? CMD_CREATE_PER : CMD_CREATE_ONE, interval, own,
                    $urandom(), {$urandom(), $urandom()});
   endtask

   task automatic cancel_timer(logic [31:0] cid);
      issue_command(CMD_CANCEL, $urandom(), $urandom(), cid, {$urandom(), $urandom()});
   endtask

   task automatic advance_time(logic [63:0] delta);
      issue_command(CMD_ADVANCE, $urandom(), $urandom(), $urandom(), delta);
   endtask

   function automatic logic [31:0] live_timer_id();
      int pick;
      pick = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
         if (tm_valid[(pick + i) % SLOTS]) return tm_id[(pick + i) % SLOTS];
      end
      return $urandom();
   endfunction

   task automatic test_create_extremes();
      add_timer(1'b0, 32'd0, 32'd0);
      add_timer(1'b1, 32'd0, 32'hFFFF_FFFF);
      add_timer(1'b0, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
      add_timer(1'b1, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
      for (int i = 0; i < 13; i++) add_timer(i[0], 32'd1000 + i, i);
      add_timer(1'b1, 32'd5, 32'd77);
   endtask

   task automatic test_cancel_paths();
      cancel_timer(32'd3);
      cancel_timer(32'd3);
      cancel_timer(32'd0);
      cancel_timer(32'hFFFF_FFFF);
      cancel_timer(32'd10);
      add_timer(1'b0, 32'd50, 32'd1234);
   endtask

   task automatic test_fire_cap_and_wrap();
      advance_time(64'd0);
      advance_time(64'd2000);
      advance_time(64'd0);
      advance_time(64'hFFFF_FFFF_FFFF_FF00);
      advance_time(64'd0);
      for (int i = 0; i < SLOTS; i++) begin
         if (tm_valid[i]) cancel_timer(tm_id[i]);
      end
      advance_time(64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_random_traffic(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) steady_flow = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (r < 40) begin
            add_timer(1'($urandom_range(0, 1)),
                      ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300),
                      $urandom());
         end else if (r < 62) begin
            cancel_timer(($urandom_range(0, 3) == 0) ? $urandom() : live_timer_id());
         end else if (r < 97) begin
            advance_time(64'($urandom_range(0, 150)));
         end else begin
            advance_time({$urandom(), $urandom()});
         end
      end
      steady_flow = 1'b0;
   endtask

   always @(posedge clock) begin
      timer_event_t want;
      if (!reset && rsp_valid) begin
         events_seen++;
         if (rsp_kind == KIND_FIRED) fires_seen++;
         if (pending_events.size() == 0) begin
            $error("result kind %0d arrived with nothing expected", rsp_kind);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               error_count++;
            end
            if (rsp_handle !== want.handle) begin
               $error("handle: expected %0h, got %0h", want.handle, rsp_handle);
               error_count++;
            end
            if (rsp_fire_owner !== want.fire_owner) begin
               $error("fire_owner: expected %0h, got %0h", want.fire_owner, rsp_fire_owner);
               error_count++;
            end
            if (rsp_now_us !== want.now_us) begin
               $error("now_us: expected %0h, got %0h", want.now_us, rsp_now_us);
               error_count++;
            end
            if (rsp_more_pending !== want.more_pending) begin
               $error("more_pending: expected %0b, got %0b", want.more_pending,
                      rsp_more_pending);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_CREATE_ONE;
      req_interval_us = '0;
      req_owner = '0;
      req_cancel_id = '0;
      req_delta_us = '0;
      error_count = 0;
      items_sent = 0;
      events_seen = 0;
      fires_seen = 0;
      capped_advances = 0;
      idle_cycles = 0;
      steady_flow = 1'b0;
      for (int i = 0; i < SLOTS; i++) tm_valid[i] = 1'b0;
      tm_head = LIST_NONE;
      next_id = 32'd1;
      model_now = 64'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_create_extremes();
      test_cancel_paths();
      test_fire_cap_and_wrap();
      test_random_traffic(205);
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d commands, checked %0d results including %0d fires.",
               items_sent, events_seen, fires_seen);
      $display("Advances stopped by the fire cap: %0d.", capped_advances);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
